// ===== rtl/core/hkrt_pkg.sv =====
// Shared types and constants for the HID key rollover table.
package hkrt_pkg;

  localparam int SLOT_COUNT_DEF = 6;
  localparam int OUT_SLOTS      = 6;
  localparam int KEY_W          = 8;
  localparam int USAGE_W        = 16;
  localparam int MOD_W          = 8;

  typedef struct packed {
    logic               cmd;
    logic               table_req;
    logic [USAGE_W-1:0] key_code;
    logic               is_modifier;
    logic [MOD_W-1:0]   modifier_bits;
  } hkrt_event_t;

  typedef struct packed {
    logic               changed;
    logic [MOD_W-1:0]   modifiers;
    logic [USAGE_W-1:0] slot_a;
    logic [USAGE_W-1:0] slot_b;
    logic [USAGE_W-1:0] slot_c;
    logic [USAGE_W-1:0] slot_d;
    logic [USAGE_W-1:0] slot_e;
    logic [USAGE_W-1:0] slot_f;
  } hkrt_result_t;

  typedef struct packed {
    logic en;
    logic consumer;
  } hkrt_wr_ctl_t;

endpackage

// ===== rtl/core/hkrt_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transfer.
interface hkrt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/hkrt_slot_table.sv =====
// Packed slot table: one write port, one indexed read, all slots visible.
module hkrt_slot_table #(
  parameter int SLOT_COUNT = 6,
  parameter int WIDTH      = 8,
  parameter int IW         = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [IW-1:0]    rd_idx,
  output logic [WIDTH-1:0] rd_data,
  output logic [WIDTH-1:0] slots [SLOT_COUNT]
);

  logic [WIDTH-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) mem[i] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  assign rd_data = mem[rd_idx];

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) slots[i] = mem[i];
  end

endmodule

// ===== rtl/core/hkrt_seq.sv =====
// Scan/shift sequencer around a single shared slot comparator.
module hkrt_seq #(
  parameter int SLOT_COUNT = 6,
  parameter int IW         = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        start_release,
  input  logic                        start_consumer,
  input  logic [hkrt_pkg::USAGE_W-1:0] start_code,
  output logic [IW-1:0]               rd_idx,
  input  logic [hkrt_pkg::USAGE_W-1:0] rd_data,
  output hkrt_pkg::hkrt_wr_ctl_t      wr,
  output logic [IW-1:0]               wr_idx,
  output logic [hkrt_pkg::USAGE_W-1:0] wr_data,
  output logic                        busy,
  output logic                        done,
  output logic                        hit
);
  import hkrt_pkg::*;

  localparam int CW = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [USAGE_W-1:0] code;
  logic               release_op;
  logic               consumer_op;
  logic [IW-1:0]      empty_idx, empty_idx_next;
  logic               have_empty, have_empty_next;

  logic match, empty_here, last;

  assign rd_idx     = cnt[IW-1:0];
  assign match      = (rd_data == code);
  assign empty_here = (rd_data == '0);
  assign last       = (cnt == CW'(SLOT_COUNT - 1));
  assign busy       = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    empty_idx_next  = empty_idx;
    have_empty_next = have_empty;
    wr.en           = 1'b0;
    wr.consumer     = consumer_op;
    wr_idx          = cnt[IW-1:0];
    wr_data         = rd_data;
    done            = 1'b0;
    hit             = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next      = S_SCAN;
          cnt_next        = '0;
          have_empty_next = 1'b0;
        end
      end
      S_SCAN: begin
        if (match) begin
          if (!release_op) begin
            done       = 1'b1;
            state_next = S_IDLE;
          end else if (last) begin
            state_next = S_CLEAR;
          end else begin
            cnt_next   = cnt + CW'(1);
            state_next = S_SHIFT;
          end
        end else begin
          if (empty_here && !have_empty) begin
            empty_idx_next  = cnt[IW-1:0];
            have_empty_next = 1'b1;
          end
          if (last) begin
            done       = 1'b1;
            state_next = S_IDLE;
            if (!release_op && (have_empty || empty_here)) begin
              wr.en   = 1'b1;
              wr_idx  = have_empty ? empty_idx : cnt[IW-1:0];
              wr_data = code;
              hit     = 1'b1;
            end
          end else begin
            cnt_next = cnt + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        wr.en   = 1'b1;
        wr_idx  = IW'(cnt - CW'(1));
        wr_data = rd_data;
        if (last) begin
          state_next = S_CLEAR;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_CLEAR: begin
        wr.en      = 1'b1;
        wr_idx     = IW'(SLOT_COUNT - 1);
        wr_data    = '0;
        done       = 1'b1;
        hit        = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      have_empty <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      have_empty <= have_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    empty_idx <= empty_idx_next;
    if (start && state == S_IDLE) begin
      code        <= start_code;
      release_op  <= start_release;
      consumer_op <= start_consumer;
    end
  end

endmodule

// ===== rtl/core/hid_key_rollover_table_core.sv =====
// HID rollover table: two slot tables, modifier bytes and result register.
// Direct modifier event: the transfer sets a pending flag and the report is loaded from it.
// Table event: the sequencer scans the slots in order through its single comparator; a release
// that hits moves each later slot down by one and then zeroes the last slot. The report is
// loaded once the sequencer is done; no new event is taken while it is busy or a report pends.
// A held report stalls the input. Synchronous reset clears tables, modifier bytes and control.
module hid_key_rollover_table_core #(
  parameter int SLOT_COUNT = hkrt_pkg::SLOT_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  hkrt_chan_if.sink   evt,
  hkrt_chan_if.source res
);
  import hkrt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [MOD_W-1:0] real_mods, real_next;
  logic [MOD_W-1:0] vmods, vmods_next;
  logic             pend, out_valid, hit_q, mod_chg_q, sel_q;
  hkrt_result_t     res_q;

  logic acc, tbl_op, mod_chg, load;
  logic seq_busy, seq_done, seq_hit;

  hkrt_wr_ctl_t       wr;
  logic [IW-1:0]      rd_idx, wr_idx;
  logic [USAGE_W-1:0] wr_data, rd_data, cons_rd, code_in;
  logic [KEY_W-1:0]   key_rd;
  logic [KEY_W-1:0]   key_slots  [SLOT_COUNT];
  logic [USAGE_W-1:0] cons_slots [SLOT_COUNT];
  logic [USAGE_W-1:0] rep        [OUT_SLOTS];

  hkrt_event_t ev;
  assign ev = evt.payload;

  assign evt.ready = !seq_busy && !pend;
  assign acc       = evt.valid && evt.ready;
  assign tbl_op    = acc && (ev.table_req || !ev.is_modifier);
  assign code_in   = ev.table_req ? ev.key_code : {{(USAGE_W-KEY_W){1'b0}}, ev.key_code[KEY_W-1:0]};

  always_comb begin
    real_next  = real_mods;
    vmods_next = vmods;
    if (acc && !ev.table_req) begin
      if (ev.is_modifier) begin
        real_next = ev.cmd ? (real_mods & ~ev.modifier_bits) : (real_mods | ev.modifier_bits);
      end else begin
        vmods_next = ev.cmd ? (vmods & ~ev.modifier_bits) : (vmods | ev.modifier_bits);
      end
    end
    if (ev.table_req) begin
      mod_chg = 1'b0;
    end else if (ev.is_modifier) begin
      mod_chg = (real_mods | vmods) != (real_next | vmods);
    end else begin
      mod_chg = (vmods != vmods_next);
    end
  end

  hkrt_seq #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (tbl_op),
    .start_release  (ev.cmd),
    .start_consumer (ev.table_req),
    .start_code     (code_in),
    .rd_idx         (rd_idx),
    .rd_data        (rd_data),
    .wr             (wr),
    .wr_idx         (wr_idx),
    .wr_data        (wr_data),
    .busy           (seq_busy),
    .done           (seq_done),
    .hit            (seq_hit)
  );

  hkrt_slot_table #(.SLOT_COUNT(SLOT_COUNT), .WIDTH(KEY_W), .IW(IW)) u_key_tab (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr.en && !wr.consumer),
    .wr_idx  (wr_idx),
    .wr_data (wr_data[KEY_W-1:0]),
    .rd_idx  (rd_idx),
    .rd_data (key_rd),
    .slots   (key_slots)
  );

  hkrt_slot_table #(.SLOT_COUNT(SLOT_COUNT), .WIDTH(USAGE_W), .IW(IW)) u_cons_tab (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr.en && wr.consumer),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (rd_idx),
    .rd_data (cons_rd),
    .slots   (cons_slots)
  );

  assign rd_data = wr.consumer ? cons_rd : {{(USAGE_W-KEY_W){1'b0}}, key_rd};

  for (genvar i = 0; i < OUT_SLOTS; i++) begin : g_rep
    if (i < SLOT_COUNT) begin : g_live
      assign rep[i] = sel_q ? cons_slots[i] : {{(USAGE_W-KEY_W){1'b0}}, key_slots[i]};
    end else begin : g_zero
      assign rep[i] = '0;
    end
  end

  assign load = pend && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      real_mods <= '0;
      vmods     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      real_mods <= real_next;
      vmods     <= vmods_next;
      if (acc && !tbl_op) begin
        pend <= 1'b1;
      end else if (seq_done) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (acc) begin
        hit_q <= 1'b0;
      end else if (seq_done) begin
        hit_q <= seq_hit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mod_chg_q <= mod_chg;
      sel_q     <= ev.table_req;
    end
    if (load) begin
      res_q.changed   <= hit_q | mod_chg_q;
      res_q.modifiers <= real_mods | vmods;
      res_q.slot_a    <= rep[0];
      res_q.slot_b    <= rep[1];
      res_q.slot_c    <= rep[2];
      res_q.slot_d    <= rep[3];
      res_q.slot_e    <= rep[4];
      res_q.slot_f    <= rep[5];
    end
  end

  assign res.valid   = out_valid;
  assign res.payload = res_q;

endmodule
